FILE: rtl/qalb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalb_pkg
// Shared widths, byte codes and reset values for the quote-aware line breaker.
// ----------------------------------------------------------------------------
package qalb_pkg;

    localparam int CH_W   = 8;
    localparam int POS_W  = 32;
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0] LINE_SIZE_RESET = 8'd80;
    localparam logic [CNT_W-1:0] CNT_MAX         = 8'hFF;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_SLASH  = 8'h2F;

endpackage

FILE: rtl/qalb_byte_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalb_byte_if
// Text byte channel: valid/ready handshake with one byte and a last flag.
// ----------------------------------------------------------------------------
interface qalb_byte_if;
    logic                         valid;
    logic                         ready;
    logic [qalb_pkg::CH_W-1:0]    ch;
    logic                         last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

FILE: rtl/qalb_brk_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalb_brk_if
// Break position channel: valid/ready handshake with one stream position.
// ----------------------------------------------------------------------------
interface qalb_brk_if;
    logic                         valid;
    logic                         ready;
    logic [qalb_pkg::POS_W-1:0]   break_after;

    modport source (output valid, output break_after, input ready);
    modport sink   (input valid, input break_after, output ready);
endinterface

FILE: rtl/quote_aware_line_breaker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quote_aware_line_breaker
// Greedy word wrap over a query text stream, skipping quoted spans; emits the
// stream position after which a newline goes.
//
//   channel   dir  payload              request accepted when
//   i_byte    in   ch[7:0], last        i_byte.valid && i_byte.ready
//   o_brk     out  break_after[31:0]    o_brk.valid && o_brk.ready
//   cfg       in   i_cfg_data[7:0]      i_cfg_we (line width)
//
// One byte per cycle sustained while no result is stalled. A request lands in
// the input register, then passes through the scan logic into the state and
// the result register.
// Reset is synchronous; the line width returns to 80.
// A stalled result holds the scan stage; the input register takes one more
// byte only while it is empty, then ready drops.
// ----------------------------------------------------------------------------
module quote_aware_line_breaker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [qalb_pkg::CNT_W-1:0]      i_cfg_data,
    qalb_byte_if.sink                       i_byte,
    qalb_brk_if.source                      o_brk
);

    typedef enum logic [1:0] {
        QM_NONE   = 2'd0,
        QM_SINGLE = 2'd1,
        QM_DOUBLE = 2'd2
    } t_quote;

    logic                           r_in_valid;
    logic [qalb_pkg::CH_W-1:0]      r_ch;
    logic                           r_last;

    logic [qalb_pkg::CNT_W-1:0]     r_line_size;
    t_quote                         r_quote,      n_quote;
    logic [qalb_pkg::CNT_W-1:0]     r_count,      n_count;
    logic                           r_have_cand,  n_have_cand;
    logic [qalb_pkg::POS_W-1:0]     r_cand,       n_cand;
    logic [qalb_pkg::POS_W-1:0]     r_line_start, n_line_start;
    logic [qalb_pkg::POS_W-1:0]     r_pos,        n_pos;
    logic                           r_ended,      n_ended;

    logic                           r_out_valid;
    logic [qalb_pkg::POS_W-1:0]     r_break_after;

    logic                           emit;
    logic                           fire;
    logic [qalb_pkg::POS_W-1:0]     gap;
    logic [qalb_pkg::CNT_W:0]       count_inc;

    assign fire          = r_in_valid && (!r_out_valid || o_brk.ready);
    assign i_byte.ready  = !r_in_valid || fire;
    assign o_brk.valid   = r_out_valid;
    assign o_brk.break_after = r_break_after;

    assign count_inc = {1'b0, r_count} + {{qalb_pkg::CNT_W{1'b0}}, 1'b1};
    assign gap       = r_pos - n_cand;

    always_comb begin
        n_quote      = r_quote;
        n_count      = r_count;
        n_have_cand  = r_have_cand;
        n_cand       = r_cand;
        n_line_start = r_line_start;
        n_pos        = r_pos;
        n_ended      = r_ended;
        emit         = 1'b0;

        if (!r_ended) begin
            if (r_ch == qalb_pkg::CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                n_pos = r_pos + 32'd1;

                if (r_ch == qalb_pkg::CH_SQUOTE) begin
                    if (r_quote == QM_NONE) begin
                        n_quote = QM_SINGLE;
                    end else if (r_quote == QM_SINGLE) begin
                        n_quote = QM_NONE;
                    end
                end else if (r_ch == qalb_pkg::CH_DQUOTE) begin
                    if (r_quote == QM_NONE) begin
                        n_quote = QM_DOUBLE;
                    end else if (r_quote == QM_DOUBLE) begin
                        n_quote = QM_NONE;
                    end
                end

                if (n_quote == QM_NONE) begin
                    case (r_ch)
                        qalb_pkg::CH_COMMA, qalb_pkg::CH_RPAREN, qalb_pkg::CH_SPACE: begin
                            n_have_cand = 1'b1;
                            n_cand      = r_pos;
                        end
                        qalb_pkg::CH_LPAREN, qalb_pkg::CH_PLUS, qalb_pkg::CH_MINUS,
                        qalb_pkg::CH_STAR, qalb_pkg::CH_SLASH: begin
                            // the byte before would sit on the previous line
                            if (r_pos != r_line_start) begin
                                n_have_cand = 1'b1;
                                n_cand      = r_pos - 32'd1;
                            end else begin
                                n_have_cand = 1'b0;
                                n_cand      = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end

                if (r_ch == qalb_pkg::CH_NL) begin
                    n_line_start = r_pos + 32'd1;
                    n_have_cand  = 1'b0;
                    n_cand       = '0;
                    n_count      = '0;
                end else if (count_inc >= {1'b0, r_line_size} && n_have_cand) begin
                    emit         = 1'b1;
                    n_count      = (|gap[qalb_pkg::POS_W-1:qalb_pkg::CNT_W]) ?
                                   qalb_pkg::CNT_MAX : gap[qalb_pkg::CNT_W-1:0];
                    n_line_start = n_cand + 32'd1;
                    n_have_cand  = 1'b0;
                end else if (r_count != qalb_pkg::CNT_MAX) begin
                    n_count = count_inc[qalb_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_line_size  <= qalb_pkg::LINE_SIZE_RESET;
            r_quote      <= QM_NONE;
            r_count      <= '0;
            r_have_cand  <= 1'b0;
            r_cand       <= '0;
            r_line_start <= '0;
            r_pos        <= '0;
            r_ended      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_line_size <= i_cfg_data;
            end

            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end

            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_brk.ready) begin
                r_out_valid <= 1'b0;
            end

            if (fire) begin
                // last byte of a query: drop all scan state
                if (r_last) begin
                    r_quote      <= QM_NONE;
                    r_count      <= '0;
                    r_have_cand  <= 1'b0;
                    r_cand       <= '0;
                    r_line_start <= '0;
                    r_pos        <= '0;
                    r_ended      <= 1'b0;
                end else begin
                    r_quote      <= n_quote;
                    r_count      <= n_count;
                    r_have_cand  <= n_have_cand;
                    r_cand       <= n_cand;
                    r_line_start <= n_line_start;
                    r_pos        <= n_pos;
                    r_ended      <= n_ended;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_ch   <= i_byte.ch;
            r_last <= i_byte.last;
        end
        if (fire && emit) begin
            r_break_after <= n_cand;
        end
    end

endmodule

FILE: rtl/qalb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalb_checker
// Port-level checks for the quote-aware line breaker, bound to the top level.
// ----------------------------------------------------------------------------
module qalb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_ready,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [qalb_pkg::POS_W-1:0]      i_break_after
);

    // a pending result is never withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_break_after))
        else $error("break position changed while stalled");

    // reset leaves no result pending
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // input backpressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // with no pending result and nothing stalled, the input side is open
    a_ready_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !i_out_valid |-> i_in_ready)
        else $error("input not ready while output empty");

endmodule

bind quote_aware_line_breaker qalb_checker u_qalb_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_byte.ready),
    .i_out_valid   (o_brk.valid),
    .i_out_ready   (o_brk.ready),
    .i_break_after (o_brk.break_after)
);

FILE: verif/qalb_break_sb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qalb_break_sb_pkg
// Break-position scoreboard for the quote-aware line breaker: tracks quote
// spans, the held break point and the line count per accepted byte request,
// and queues the break positions the block must produce.
// ----------------------------------------------------------------------------
package qalb_break_sb_pkg;

    import qalb_pkg::*;

    typedef enum logic [1:0] {
        IN_PLAIN  = 2'd0,
        IN_SINGLE = 2'd1,
        IN_DOUBLE = 2'd2
    } t_scan_mode;

    class break_scoreboard;
        logic [CNT_W-1:0] wrap_width;
        t_scan_mode       mode;
        logic [CNT_W-1:0] line_count;
        bit               cand_valid;
        logic [POS_W-1:0] cand_pos;
        logic [POS_W-1:0] line_start;
        logic [POS_W-1:0] next_pos;
        bit               ended;
        logic [POS_W-1:0] expected_breaks[$];
        int               errors;
        int               breaks_checked;

        function new();
            wrap_width     = LINE_SIZE_RESET;
            errors         = 0;
            breaks_checked = 0;
            clear_scan();
        endfunction

        function void clear_scan();
            mode       = IN_PLAIN;
            line_count = '0;
            cand_valid = 1'b0;
            cand_pos   = '0;
            line_start = '0;
            next_pos   = '0;
            ended      = 1'b0;
        endfunction

        function void set_wrap_width(input logic [CNT_W-1:0] value);
            wrap_width = value;
        endfunction

        function int pending();
            return expected_breaks.size();
        endfunction

        // Advance the scan state by one accepted byte request.
        function void note_byte(input logic [CH_W-1:0] c, input logic fin);
            logic [POS_W-1:0] p;
            logic [POS_W-1:0] gap;
            t_scan_mode       m;
            if (!ended) begin
                if (c == CH_NUL) begin
                    ended = 1'b1;
                end else begin
                    p        = next_pos;
                    next_pos = next_pos + 32'd1;
                    if (c == CH_SQUOTE || c == CH_DQUOTE) begin
                        m = (c == CH_SQUOTE) ? IN_SINGLE : IN_DOUBLE;
                        if (mode == IN_PLAIN)
                            mode = m;
                        else if (mode == m)
                            mode = IN_PLAIN;
                    end
                    if (mode == IN_PLAIN) begin
                        if (c == CH_COMMA || c == CH_RPAREN || c == CH_SPACE) begin
                            cand_valid = 1'b1;
                            cand_pos   = p;
                        end else if (c == CH_LPAREN || c == CH_PLUS || c == CH_MINUS ||
                                     c == CH_STAR || c == CH_SLASH) begin
                            // the byte before would lie on the previous line
                            if (p != line_start) begin
                                cand_valid = 1'b1;
                                cand_pos   = p - 32'd1;
                            end else begin
                                cand_valid = 1'b0;
                                cand_pos   = '0;
                            end
                        end
                    end
                    if (c == CH_NL) begin
                        line_start = p + 32'd1;
                        cand_valid = 1'b0;
                        cand_pos   = '0;
                        line_count = '0;
                    end else if (({1'b0, line_count} + 9'd1 >= {1'b0, wrap_width}) &&
                                 cand_valid) begin
                        gap = p - cand_pos;
                        expected_breaks.push_back(cand_pos);
                        line_count = (gap > 32'd255) ? CNT_MAX : gap[CNT_W-1:0];
                        line_start = cand_pos + 32'd1;
                        cand_valid = 1'b0;
                        cand_pos   = '0;
                    end else if (line_count != CNT_MAX) begin
                        line_count = line_count + 8'd1;
                    end
                end
            end
            if (fin)
                clear_scan();
        endfunction

        function void check_break(input logic [POS_W-1:0] got);
            logic [POS_W-1:0] want;
            if (expected_breaks.size() == 0) begin
                $error("break_after: no result expected, actual %0d", got);
                errors++;
            end else begin
                want = expected_breaks.pop_front();
                breaks_checked++;
                if (got !== want) begin
                    $error("break_after mismatch: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives query text into the quote-aware line breaker at several line widths,
// with directed corner bytes and random queries, random stalls on
// both channels, and checks every break position against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;

    import qalb_pkg::*;
    import qalb_break_sb_pkg::*;

    localparam int DRAIN_CYCLES = 6;
    localparam int LONG_HOLD    = 60;
    localparam int STALL_LIMIT  = 1000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    qalb_byte_if byte_if ();
    qalb_brk_if  brk_if ();

    quote_aware_line_breaker dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_byte     (byte_if),
        .o_brk      (brk_if)
    );

    break_scoreboard sb = new();

    logic [CH_W-1:0] query_buf[$];
    bit              src_idle;
    bit              phase_idle;
    bit              sink_idle;
    bit              long_hold_req;
    int              bytes_sent;
    int              widths_run;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [CH_W-1:0] word_char();
        if ($urandom_range(0, 5) == 0)
            return CH_W'($urandom_range(48, 57));
        return CH_W'($urandom_range(97, 122));
    endfunction

    function automatic logic [CH_W-1:0] pick_op();
        case ($urandom_range(0, 3))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            default: return CH_SLASH;
        endcase
    endfunction

    // Anything but the closing quote itself.
    function automatic logic [CH_W-1:0] quoted_char(input logic [CH_W-1:0] q);
        case ($urandom_range(0, 9))
            0:       return CH_SPACE;
            1:       return CH_COMMA;
            2:       return CH_LPAREN;
            3:       return CH_RPAREN;
            4:       return pick_op();
            5:       return (q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE;
            default: return word_char();
        endcase
    endfunction

    task automatic push_byte(input logic [CH_W-1:0] c, input logic fin);
        if (src_idle && $urandom_range(0, 4) == 0) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.ch    <= c;
        byte_if.last  <= fin;
        do @(posedge i_clk); while (byte_if.ready !== 1'b1);
        sb.note_byte(c, fin);
        bytes_sent++;
    endtask

    // Hold the sender until every break has come and the pipe is quiet.
    task automatic drain();
        byte_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_wrap_width(input logic [CNT_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_wrap_width(value);
        widths_run++;
    endtask

    task automatic build_query(input int target_len, input bit long_word);
        logic [CH_W-1:0] q;
        query_buf.delete();
        // a word this long with no break point drives the count to saturation
        if (long_word)
            repeat ($urandom_range(270, 320)) query_buf.push_back(word_char());
        while (query_buf.size() < target_len) begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6:
                    repeat ($urandom_range(1, 10)) query_buf.push_back(word_char());
                7, 8: query_buf.push_back(CH_SPACE);
                9: begin
                    query_buf.push_back(CH_COMMA);
                    query_buf.push_back(CH_SPACE);
                end
                10: query_buf.push_back(CH_LPAREN);
                11: query_buf.push_back(CH_RPAREN);
                12: query_buf.push_back(pick_op());
                13, 14: begin
                    q = ($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE;
                    query_buf.push_back(q);
                    repeat ($urandom_range(0, 15)) query_buf.push_back(quoted_char(q));
                    query_buf.push_back(q);
                end
                15: query_buf.push_back(CH_NL);
                16: query_buf.push_back(CH_W'($urandom_range(1, 255)));
                17: query_buf.push_back(($urandom_range(0, 1) != 0) ? CH_SQUOTE : CH_DQUOTE);
                default: query_buf.push_back(word_char());
            endcase
        end
        // early terminator, then bytes the block must skip
        if ($urandom_range(0, 7) == 0) begin
            query_buf.push_back(CH_NUL);
            repeat ($urandom_range(0, 4)) query_buf.push_back(CH_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_query(input int target_len, input bit long_word);
        build_query(target_len, long_word);
        src_idle = phase_idle && ($urandom_range(0, 3) != 0);
        foreach (query_buf[k])
            push_byte(query_buf[k], k == query_buf.size() - 1);
    endtask

    task automatic run_phase(input logic [CNT_W-1:0] width, input int n_bytes,
                             input bit long_word, input bit idling, input bit hold_sink);
        int  start;
        bit  first;
        drain();
        write_wrap_width(width);
        phase_idle = idling;
        sink_idle  = idling;
        if (hold_sink)
            long_hold_req = 1'b1;
        start = bytes_sent;
        first = long_word;
        while (bytes_sent - start < n_bytes) begin
            send_query(first ? 360 : $urandom_range(10, 120), first);
            first = 1'b0;
        end
    endtask

    task automatic run_directed();
        drain();
        write_wrap_width(8'd2);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        push_byte(CH_LPAREN, 1'b0);     // operator opening a line
        push_byte("a", 1'b0);
        push_byte(CH_PLUS, 1'b0);
        push_byte("b", 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_COMMA, 1'b0);
        push_byte(CH_RPAREN, 1'b0);
        push_byte(CH_MINUS, 1'b0);
        push_byte(CH_STAR, 1'b0);
        push_byte(CH_SLASH, 1'b0);
        push_byte(CH_SQUOTE, 1'b0);
        push_byte(CH_SPACE, 1'b0);
        push_byte(CH_DQUOTE, 1'b0);     // other quote inside a span
        push_byte(CH_SQUOTE, 1'b0);
        push_byte(CH_DQUOTE, 1'b0);
        push_byte(CH_COMMA, 1'b0);
        push_byte(CH_DQUOTE, 1'b0);
        push_byte(CH_NL, 1'b0);
        push_byte(CH_PLUS, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(CH_NUL, 1'b0);        // terminator, rest is skipped
        push_byte("x", 1'b0);
        push_byte(CH_COMMA, 1'b1);
        push_byte(CH_NUL, 1'b1);
    endtask

    // Result side: check accepted breaks, then pick next cycle's ready.
    initial begin
        int hold;
        hold = 0;
        brk_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && brk_if.valid === 1'b1 && brk_if.ready === 1'b1)
                sb.check_break(brk_if.break_after);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                hold--;
                brk_if.ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 2);
                brk_if.ready <= 1'b0;
            end else begin
                brk_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((byte_if.valid === 1'b1 && byte_if.ready === 1'b1) ||
                (brk_if.valid === 1'b1 && brk_if.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_data    <= '0;
        byte_if.valid <= 1'b0;
        byte_if.ch    <= '0;
        byte_if.last  <= 1'b0;
        src_idle      = 1'b0;
        phase_idle    = 1'b0;
        sink_idle     = 1'b0;
        long_hold_req = 1'b0;
        bytes_sent    = 0;
        widths_run    = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(LINE_SIZE_RESET, 100, 1'b0, 1'b1, 1'b0);
        run_phase(CNT_MAX, 300, 1'b1, 1'b1, 1'b0);
        run_phase(8'd3, 90, 1'b0, 1'b1, 1'b1);
        run_phase(CNT_W'($urandom_range(4, 40)), 100, 1'b0, 1'b1, 1'b0);
        run_phase(8'd12, 70, 1'b0, 1'b1, 1'b0);
        // full rate on both sides to close out
        run_phase(8'd2, 60, 1'b0, 1'b0, 1'b0);
        drain();

        $display("ran %0d text bytes over %0d line widths (2 to 255, quotes, terminators)",
                 bytes_sent, widths_run);
        $display("checked %0d break positions, %0d mismatches", sb.breaks_checked, sb.errors);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
